>>> hdl/sbl_pkg.sv
// Shared types and constants for the source byte lexer.
// Holds the transfer structs, token kind and error codes, and the keyword table.
// No dependencies.
package sbl_pkg;

   // Input transfer: one source byte and the end-of-source flag
   typedef struct packed {
      logic [7:0] ch;
      logic       at_end;
   } req_type;

   // Result transfer: one token
   typedef struct packed {
      logic [5:0]  kind;
      logic [1:0]  error_code;
      logic [15:0] start_offset;
      logic [15:0] token_length;
      logic [15:0] line_number;
      logic [15:0] column_number;
      logic        last;
   } rsp_type;

   // Token kinds
   localparam logic [5:0] K_EOF      = 6'd0;
   localparam logic [5:0] K_LPAREN   = 6'd1;
   localparam logic [5:0] K_RPAREN   = 6'd2;
   localparam logic [5:0] K_LBRACE   = 6'd3;
   localparam logic [5:0] K_RBRACE   = 6'd4;
   localparam logic [5:0] K_PLUS     = 6'd5;
   localparam logic [5:0] K_MINUS    = 6'd6;
   localparam logic [5:0] K_STAR     = 6'd7;
   localparam logic [5:0] K_SLASH    = 6'd8;
   localparam logic [5:0] K_SEMI     = 6'd9;
   localparam logic [5:0] K_COMMA    = 6'd10;
   localparam logic [5:0] K_DOT      = 6'd11;
   localparam logic [5:0] K_BANG     = 6'd12;
   localparam logic [5:0] K_ASSIGN   = 6'd14;
   localparam logic [5:0] K_GT       = 6'd16;
   localparam logic [5:0] K_LT       = 6'd18;
   localparam logic [5:0] K_STRING   = 6'd20;
   localparam logic [5:0] K_INT      = 6'd21;
   localparam logic [5:0] K_DEC      = 6'd22;
   localparam logic [5:0] K_IDENT    = 6'd23;
   localparam logic [5:0] K_KEYWORD0 = 6'd24;
   localparam logic [5:0] K_ILLEGAL  = 6'd39;

   // Error codes
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_UNTERM_STR = 2'd1;
   localparam logic [1:0] ERR_UNEXPECTED = 2'd2;

   localparam int KW_COUNT = 15;

   // Keywords packed little-endian, first character in the low byte
   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      64'h0000_0000_0000_6669,   // if
      64'h0000_0000_6573_6c65,   // else
      64'h0000_6e72_7574_6572,   // return
      64'h0000_0065_6c69_6877,   // while
      64'h0000_0000_0072_6f66,   // for
      64'h0000_0000_6575_7274,   // true
      64'h0000_0065_736c_6166,   // false
      64'h0000_0000_0074_6e69,   // int
      64'h0000_0000_746e_6975,   // uint
      64'h0000_0074_616f_6c66,   // float
      64'h0000_656c_6275_6f64,   // double
      64'h0000_0000_6c6f_6f62,   // bool
      64'h0000_0000_6469_6f76,   // void
      64'h0000_7463_7572_7473,   // struct
      64'h0000_0000_6d75_6e65    // enum
   };

endpackage

>>> hdl/sbl_core.sv
// Scanner core: mode, keyword buffer and position counters, plus the
// per-byte step logic that yields up to three tokens. Depends on sbl_pkg.
module sbl_core
   import sbl_pkg::*;
#(
   parameter int POSITION_BITS     = 16,
   parameter int KEYWORD_MAX_CHARS = 6
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  req_type    req_data,
   output rsp_type    res_tok [3],
   output logic [1:0] res_count
);

   localparam int P  = POSITION_BITS;
   localparam int KB = 8 * KEYWORD_MAX_CHARS;

   localparam logic [7:0] C_TAB   = 8'h09;
   localparam logic [7:0] C_LF    = 8'h0a;
   localparam logic [7:0] C_CR    = 8'h0d;
   localparam logic [7:0] C_SPACE = 8'h20;
   localparam logic [7:0] C_BANG  = 8'h21;
   localparam logic [7:0] C_QUOTE = 8'h22;
   localparam logic [7:0] C_HASH  = 8'h23;
   localparam logic [7:0] C_DOT   = 8'h2e;
   localparam logic [7:0] C_EQ    = 8'h3d;
   localparam logic [7:0] C_GT    = 8'h3e;
   localparam logic [7:0] C_LT    = 8'h3c;

   typedef enum logic [2:0] {
      M_IDLE, M_COMMENT, M_STRING, M_INT, M_INT_DOT, M_FRAC, M_IDENT, M_OP
   } mode_type;

   mode_type        mode_ff, mode_in;
   logic [7:0]      pend_ff, pend_in;
   logic [KB-1:0]   kbuf_ff, kbuf_in;
   logic            ktl_ff, ktl_in;
   logic [P-1:0]    off_ff, off_in;
   logic [P-1:0]    tst_ff, tst_in;
   logic [P-1:0]    line_ff, line_in;
   logic [P-1:0]    col_ff, col_in;

   function automatic logic [P-1:0] sat_inc(input logic [P-1:0] v);
      return (v == {P{1'b1}}) ? v : v + 1'b1;
   endfunction

   function automatic logic [15:0] to16(input logic [P-1:0] v);
      logic [P+15:0] wide;
      wide = {16'b0, v};
      return wide[15:0];
   endfunction

   function automatic rsp_type make_tok(input logic [5:0] k, input logic [1:0] e,
                                        input logic [P-1:0] ts, input logic [P-1:0] of,
                                        input logic [P-1:0] ln, input logic [P-1:0] cl);
      rsp_type t;
      t.kind          = k;
      t.error_code    = e;
      t.start_offset  = to16(ts);
      t.token_length  = to16((of >= ts) ? of - ts : '0);
      t.line_number   = to16(ln);
      t.column_number = to16(cl);
      t.last          = 1'b0;
      return t;
   endfunction

   function automatic logic [5:0] op_kind(input logic [7:0] c);
      priority case (c)
         C_BANG:  return K_BANG;
         C_EQ:    return K_ASSIGN;
         C_GT:    return K_GT;
         default: return K_LT;
      endcase
   endfunction

   function automatic logic [5:0] ident_kind(input logic [KB-1:0] kb, input logic tl);
      logic [63:0] wide;
      logic [5:0]  k;
      wide = '0;
      wide[KB-1:0] = kb;
      k = K_IDENT;
      if (!tl) begin
         for (int i = 0; i < KW_COUNT; i++) begin
            if (KW_TEXT[i] == wide) k = K_KEYWORD0 + 6'(i);
         end
      end
      return k;
   endfunction

   // Step logic for one byte
   always_comb begin
      logic [7:0] c;
      logic       is_dig, is_alp, do_idle, placed;
      logic [1:0] n;
      c       = req_data.ch;
      is_dig  = (c >= 8'h30) && (c <= 8'h39);
      is_alp  = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a))
                || (c == 8'h5f);
      do_idle = 1'b0;
      placed  = 1'b0;
      n       = '0;
      mode_in = mode_ff;
      pend_in = pend_ff;
      kbuf_in = kbuf_ff;
      ktl_in  = ktl_ff;
      off_in  = off_ff;
      tst_in  = tst_ff;
      line_in = line_ff;
      col_in  = col_ff;
      for (int i = 0; i < 3; i++) res_tok[i] = '0;

      if (req_data.at_end) begin
         // Flush any pending tokens, then EOF, then restart all counters
         unique case (mode_ff)
            M_STRING: begin
               res_tok[n] = make_tok(K_ILLEGAL, ERR_UNTERM_STR, tst_in, off_in, line_in, col_in);
               n = n + 1'b1;
            end
            M_INT: begin
               res_tok[n] = make_tok(K_INT, ERR_NONE, tst_in, off_in, line_in, col_in);
               n = n + 1'b1;
            end
            M_INT_DOT: begin
               res_tok[n] = make_tok(K_INT, ERR_NONE, tst_in, off_in, line_in, col_in);
               n = n + 1'b1;
               tst_in = off_in;
               off_in = sat_inc(off_in);
               col_in = sat_inc(col_in);
               res_tok[n] = make_tok(K_DOT, ERR_NONE, tst_in, off_in, line_in, col_in);
               n = n + 1'b1;
            end
            M_FRAC: begin
               res_tok[n] = make_tok(K_DEC, ERR_NONE, tst_in, off_in, line_in, col_in);
               n = n + 1'b1;
            end
            M_IDENT: begin
               res_tok[n] = make_tok(ident_kind(kbuf_ff, ktl_ff), ERR_NONE,
                                     tst_in, off_in, line_in, col_in);
               n = n + 1'b1;
            end
            M_OP: begin
               res_tok[n] = make_tok(op_kind(pend_ff), ERR_NONE,
                                     tst_in, off_in, line_in, col_in);
               n = n + 1'b1;
            end
            M_IDLE, M_COMMENT: ;
         endcase
         tst_in = off_in;
         res_tok[n] = make_tok(K_EOF, ERR_NONE, tst_in, off_in, line_in, col_in);
         n = n + 1'b1;
         mode_in = M_IDLE;
         pend_in = '0;
         kbuf_in = '0;
         ktl_in  = 1'b0;
         off_in  = '0;
         tst_in  = '0;
         line_in = P'(1);
         col_in  = P'(1);
      end else begin
         // Mode-specific handling; do_idle rescans the byte as a fresh start
         unique case (mode_ff)
            M_IDLE: do_idle = 1'b1;
            M_COMMENT: begin
               if (c == C_LF) begin
                  mode_in = M_IDLE;
                  do_idle = 1'b1;
               end else begin
                  off_in = sat_inc(off_in);
                  col_in = sat_inc(col_in);
               end
            end
            M_STRING: begin
               if (c == C_QUOTE) begin
                  off_in = sat_inc(off_in);
                  col_in = sat_inc(col_in);
                  res_tok[n] = make_tok(K_STRING, ERR_NONE, tst_in, off_in, line_in, col_in);
                  n = n + 1'b1;
                  mode_in = M_IDLE;
               end else begin
                  if (c == C_LF) begin
                     line_in = sat_inc(line_in);
                     col_in  = '0;
                  end
                  off_in = sat_inc(off_in);
                  col_in = sat_inc(col_in);
               end
            end
            M_INT: begin
               if (is_dig) begin
                  off_in = sat_inc(off_in);
                  col_in = sat_inc(col_in);
               end else if (c == C_DOT) begin
                  mode_in = M_INT_DOT;
               end else begin
                  res_tok[n] = make_tok(K_INT, ERR_NONE, tst_in, off_in, line_in, col_in);
                  n = n + 1'b1;
                  mode_in = M_IDLE;
                  do_idle = 1'b1;
               end
            end
            M_INT_DOT: begin
               if (is_dig) begin
                  off_in = sat_inc(sat_inc(off_in));
                  col_in = sat_inc(sat_inc(col_in));
                  mode_in = M_FRAC;
               end else begin
                  res_tok[n] = make_tok(K_INT, ERR_NONE, tst_in, off_in, line_in, col_in);
                  n = n + 1'b1;
                  tst_in = off_in;
                  off_in = sat_inc(off_in);
                  col_in = sat_inc(col_in);
                  res_tok[n] = make_tok(K_DOT, ERR_NONE, tst_in, off_in, line_in, col_in);
                  n = n + 1'b1;
                  mode_in = M_IDLE;
                  do_idle = 1'b1;
               end
            end
            M_FRAC: begin
               if (is_dig) begin
                  off_in = sat_inc(off_in);
                  col_in = sat_inc(col_in);
               end else begin
                  res_tok[n] = make_tok(K_DEC, ERR_NONE, tst_in, off_in, line_in, col_in);
                  n = n + 1'b1;
                  mode_in = M_IDLE;
                  do_idle = 1'b1;
               end
            end
            M_IDENT: begin
               if (is_dig || is_alp) begin
                  // Append into the first free byte, else mark as too long
                  for (int i = 0; i < KEYWORD_MAX_CHARS; i++) begin
                     if (!placed && kbuf_in[8*i +: 8] == 8'h00) begin
                        kbuf_in[8*i +: 8] = c;
                        placed = 1'b1;
                     end
                  end
                  if (!placed) ktl_in = 1'b1;
                  off_in = sat_inc(off_in);
                  col_in = sat_inc(col_in);
               end else begin
                  res_tok[n] = make_tok(ident_kind(kbuf_ff, ktl_ff), ERR_NONE,
                                        tst_in, off_in, line_in, col_in);
                  n = n + 1'b1;
                  mode_in = M_IDLE;
                  do_idle = 1'b1;
               end
            end
            M_OP: begin
               mode_in = M_IDLE;
               if (c == C_EQ) begin
                  off_in = sat_inc(off_in);
                  col_in = sat_inc(col_in);
                  res_tok[n] = make_tok(op_kind(pend_ff) + 6'd1, ERR_NONE,
                                        tst_in, off_in, line_in, col_in);
                  n = n + 1'b1;
               end else begin
                  res_tok[n] = make_tok(op_kind(pend_ff), ERR_NONE,
                                        tst_in, off_in, line_in, col_in);
                  n = n + 1'b1;
                  do_idle = 1'b1;
               end
            end
         endcase

         // Scan the byte from between tokens
         if (do_idle) begin
            if (c == C_SPACE || c == C_TAB || c == C_CR) begin
               off_in = sat_inc(off_in);
               col_in = sat_inc(col_in);
            end else if (c == C_LF) begin
               line_in = sat_inc(line_in);
               off_in  = sat_inc(off_in);
               col_in  = P'(1);
            end else if (c == C_HASH) begin
               mode_in = M_COMMENT;
               off_in  = sat_inc(off_in);
               col_in  = sat_inc(col_in);
            end else begin
               tst_in = off_in;
               off_in = sat_inc(off_in);
               col_in = sat_inc(col_in);
               priority if (c == C_BANG || c == C_EQ || c == C_GT || c == C_LT) begin
                  pend_in = c;
                  mode_in = M_OP;
               end else if (c == C_QUOTE) begin
                  mode_in = M_STRING;
               end else if (is_dig) begin
                  mode_in = M_INT;
               end else if (is_alp) begin
                  kbuf_in = '0;
                  kbuf_in[7:0] = c;
                  ktl_in  = 1'b0;
                  mode_in = M_IDENT;
               end else begin
                  unique case (c)
                     8'h28:   res_tok[n] = make_tok(K_LPAREN, ERR_NONE, tst_in, off_in,
                                                    line_in, col_in);
                     8'h29:   res_tok[n] = make_tok(K_RPAREN, ERR_NONE, tst_in, off_in,
                                                    line_in, col_in);
                     8'h7b:   res_tok[n] = make_tok(K_LBRACE, ERR_NONE, tst_in, off_in,
                                                    line_in, col_in);
                     8'h7d:   res_tok[n] = make_tok(K_RBRACE, ERR_NONE, tst_in, off_in,
                                                    line_in, col_in);
                     8'h2b:   res_tok[n] = make_tok(K_PLUS, ERR_NONE, tst_in, off_in,
                                                    line_in, col_in);
                     8'h2d:   res_tok[n] = make_tok(K_MINUS, ERR_NONE, tst_in, off_in,
                                                    line_in, col_in);
                     8'h2a:   res_tok[n] = make_tok(K_STAR, ERR_NONE, tst_in, off_in,
                                                    line_in, col_in);
                     8'h2f:   res_tok[n] = make_tok(K_SLASH, ERR_NONE, tst_in, off_in,
                                                    line_in, col_in);
                     8'h3b:   res_tok[n] = make_tok(K_SEMI, ERR_NONE, tst_in, off_in,
                                                    line_in, col_in);
                     8'h2c:   res_tok[n] = make_tok(K_COMMA, ERR_NONE, tst_in, off_in,
                                                    line_in, col_in);
                     C_DOT:   res_tok[n] = make_tok(K_DOT, ERR_NONE, tst_in, off_in,
                                                    line_in, col_in);
                     default: res_tok[n] = make_tok(K_ILLEGAL, ERR_UNEXPECTED, tst_in,
                                                    off_in, line_in, col_in);
                  endcase
                  n = n + 1'b1;
               end
            end
         end
      end

      // Flag the final token of this byte
      if (n != 2'd0) res_tok[n - 2'd1].last = 1'b1;
      res_count = n;
   end

   // Hold scanner state; advance on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         pend_ff <= '0;
         kbuf_ff <= '0;
         ktl_ff  <= 1'b0;
         off_ff  <= '0;
         tst_ff  <= '0;
         line_ff <= P'(1);
         col_ff  <= P'(1);
      end else if (step) begin
         mode_ff <= mode_in;
         pend_ff <= pend_in;
         kbuf_ff <= kbuf_in;
         ktl_ff  <= ktl_in;
         off_ff  <= off_in;
         tst_ff  <= tst_in;
         line_ff <= line_in;
         col_ff  <= col_in;
      end
   end

endmodule

>>> hdl/source_byte_lexer.sv
// Source byte lexer: its tokens (zero to three per byte) are registered in a
// four-entry token queue and leave on rsp one per cycle while rsp_stall is low.
// With rsp_stall low, the rate is one byte per cycle while bytes yield at most
// one token each; a byte giving more tokens holds req_stall until the queue
// drains to one entry. Reset (synchronous) empties the queue, idles the
// scanner, line and column at 1. Depends on sbl_pkg and sbl_core.
module source_byte_lexer
   import sbl_pkg::*;
#(
   parameter int POSITION_BITS     = 16,
   parameter int KEYWORD_MAX_CHARS = 6
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int DEPTH = 4;

   rsp_type     res_tok [3];
   logic [1:0]  res_count;
   logic        req_xfer, rsp_xfer;

   rsp_type     queue_ff [DEPTH];
   logic [1:0]  wr_ptr_ff, wr_ptr_in;
   logic [1:0]  rd_ptr_ff, rd_ptr_in;
   logic [2:0]  count_ff, count_in;

   assign req_stall = (count_ff > 3'd1);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_xfer  = rsp_valid && !rsp_stall;
   assign rsp_data  = queue_ff[rd_ptr_ff];

   sbl_core #(
      .POSITION_BITS     (POSITION_BITS),
      .KEYWORD_MAX_CHARS (KEYWORD_MAX_CHARS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (req_xfer),
      .req_data  (req_data),
      .res_tok   (res_tok),
      .res_count (res_count)
   );

   // Advance queue pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + (req_xfer ? res_count : 2'd0);
      rd_ptr_in = rd_ptr_ff + {1'b0, rsp_xfer};
      count_in  = count_ff + (req_xfer ? {1'b0, res_count} : 3'd0) - {2'b0, rsp_xfer};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write the tokens of an accepted byte into consecutive entries
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         for (int i = 0; i < 3; i++) begin
            if (2'(i) < res_count) queue_ff[wr_ptr_ff + 2'(i)] <= res_tok[i];
         end
      end
   end

   // Queue never overfills
   assert property (@(posedge clock) disable iff (reset) count_ff <= 3'(DEPTH))
      else $error("token queue overflow");

   // End of source always yields at least the EOF token
   assert property (@(posedge clock) disable iff (reset)
                    req_xfer && req_data.at_end |=> rsp_valid)
      else $error("no token after end of source");

   // With no byte accepted, each delivered token drops the count by one
   assert property (@(posedge clock) disable iff (reset)
                    rsp_xfer && !req_xfer |=> count_ff == $past(count_ff) - 3'd1)
      else $error("token queue count mismatch");

endmodule
